/* design/pphd_pkg.sv */
// ----------------------------------------------------------------------------
// pphd_pkg: shared types and constants for the proximity haptic duty block
// tier thresholds, duty table, register indexes and the pair write record
// ----------------------------------------------------------------------------
package pphd_pkg;

  localparam int unsigned NUM_SENSORS = 4;
  localparam int unsigned DIST_W      = 16;
  localparam int unsigned DUTY_W      = 13;
  localparam int unsigned BOUND_W     = 15;
  localparam int unsigned CFG_IDX_W   = 8;

  typedef logic signed [DIST_W-1:0] dist_t;
  typedef logic [DUTY_W-1:0]        duty_t;
  typedef logic [BOUND_W-1:0]       bound_t;
  typedef logic [2:0]               tier_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  // tier thresholds in q8.8 feet
  localparam dist_t Q_TWO   = 16'sd512;
  localparam dist_t Q_THREE = 16'sd768;
  localparam dist_t Q_FOUR  = 16'sd1024;
  localparam dist_t Q_FIVE  = 16'sd1280;
  localparam dist_t Q_SIX   = 16'sd1536;

  localparam tier_t TIER_NONE = 3'd0;

  localparam duty_t DUTY_T1 = 13'd8191;
  localparam duty_t DUTY_T2 = 13'd6552;
  localparam duty_t DUTY_T3 = 13'd4914;
  localparam duty_t DUTY_T4 = 13'd3276;
  localparam duty_t DUTY_T5 = 13'd1638;

  // register indexes
  localparam cfg_idx_t CFG_NO_READING_LEVEL = 8'd0;
  localparam cfg_idx_t CFG_NEAR_SPAN        = 8'd1;

  localparam dist_t  NO_READING_RESET = 16'sd0;
  localparam bound_t BOUNDARY_RESET   = 15'd64;

  // what one neighbor pair writes into the motor row
  typedef struct packed {
    logic  wr_i;
    logic  wr_j;
    duty_t duty_i;
    duty_t duty_j;
  } pair_wr_t;

  function automatic duty_t duty_of_tier(input tier_t t);
    duty_t d;
    case (t)
      3'd1:    d = DUTY_T1;
      3'd2:    d = DUTY_T2;
      3'd3:    d = DUTY_T3;
      3'd4:    d = DUTY_T4;
      3'd5:    d = DUTY_T5;
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

/* design/proximity_pair_haptic_duty.sv */
// ----------------------------------------------------------------------------
// proximity_pair_haptic_duty: four distance readings to four motor duties
// tier lanes, pair lanes, motor merge and a skid-buffered output register
// ----------------------------------------------------------------------------
// usage
//   s_axis: one transfer carries four signed q8.8 readings (a in the low bits)
//   m_axis: one transfer carries four 13-bit duties, one result per input
//   cfg: register write channel, always ready; index 0 is the no-reading
//     level, index 1 is the near span, other indexes are ignored
// throughput
//   one input transfer per cycle while s_axis_tready is high; the result
//   goes to the output register, or to the skid slot while m_axis stalls;
//   all tier, pair and merge logic is combinational ahead of the register
// reset
//   rst_ni clears both output slots; registers return to level 0 and
//   near span 64 (0.25 ft)
// stall
//   a result waiting on m_axis does not stop input: a second result goes to
//   the skid slot, and only with both slots full does s_axis_tready drop
// ----------------------------------------------------------------------------
module proximity_pair_haptic_duty (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [63:0]                    s_axis_tdata,  // dist_d, dist_c, dist_b, dist_a
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [55:0]                    m_axis_tdata,  // 4'b0, duty_d, duty_c, duty_b, duty_a
  // register write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  pphd_pkg::cfg_idx_t             cfg_index_i,
  input  logic [15:0]                    cfg_data_i
);

  localparam int unsigned N       = pphd_pkg::NUM_SENSORS;
  localparam int unsigned DW      = pphd_pkg::DIST_W;
  localparam int unsigned RES_W   = N * pphd_pkg::DUTY_W;

  // configuration registers
  pphd_pkg::dist_t  no_reading_level_q;
  pphd_pkg::bound_t near_span_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      no_reading_level_q <= pphd_pkg::NO_READING_RESET;
      near_span_q        <= pphd_pkg::BOUNDARY_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pphd_pkg::CFG_NO_READING_LEVEL: no_reading_level_q <= cfg_data_i;
        pphd_pkg::CFG_NEAR_SPAN:        near_span_q <= cfg_data_i[pphd_pkg::BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  // tier lanes
  pphd_pkg::dist_t reading [N];
  pphd_pkg::tier_t tier [N];

  for (genvar k = 0; k < N; k++) begin : g_tier
    assign reading[k] = s_axis_tdata[k*DW +: DW];
    pphd_tier u_tier (
      .dist_i             (reading[k]),
      .no_reading_level_i (no_reading_level_q),
      .tier_o             (tier[k])
    );
  end

  // pair lanes: (a,b), (b,c), (c,d)
  pphd_pkg::pair_wr_t pair_wr [N-1];

  for (genvar p = 0; p < N-1; p++) begin : g_pair
    pphd_pair u_pair (
      .dist_i_i    (reading[p]),
      .dist_j_i    (reading[p+1]),
      .tier_i_i    (tier[p]),
      .tier_j_i    (tier[p+1]),
      .near_span_i (near_span_q),
      .wr_o        (pair_wr[p])
    );
  end

  // merge: later pairs win on the motor they share with an earlier pair
  pphd_pkg::duty_t duty [N];

  always_comb begin
    for (int m = 0; m < N; m++) begin
      duty[m] = '0;
    end
    for (int p = 0; p < N-1; p++) begin
      if (pair_wr[p].wr_i) duty[p]   = pair_wr[p].duty_i;
      if (pair_wr[p].wr_j) duty[p+1] = pair_wr[p].duty_j;
    end
  end

  logic [RES_W-1:0] result;

  always_comb begin
    for (int m = 0; m < N; m++) begin
      result[m*pphd_pkg::DUTY_W +: pphd_pkg::DUTY_W] = duty[m];
    end
  end

  // output register with skid slot
  logic             out_valid_q, skid_valid_q;
  logic [RES_W-1:0] out_data_q, skid_data_q;
  logic             in_xfer, out_xfer;

  assign s_axis_tready = !skid_valid_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = out_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_xfer) begin
        out_valid_q  <= skid_valid_q || in_xfer;
        skid_valid_q <= 1'b0;
      end else if (in_xfer) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_xfer) begin
      out_data_q <= skid_valid_q ? skid_data_q : result;
    end
    if (in_xfer && out_valid_q && !out_xfer) begin
      skid_data_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_data_q};

  // checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot holds a result while the output slot is empty");

  a_accept_gives_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_q)
    else $error("accepted item left no result pending");

  a_duty_a_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[12:0] == 13'd0 || out_data_q[12:0] == pphd_pkg::DUTY_T1 ||
                     out_data_q[12:0] == pphd_pkg::DUTY_T2 ||
                     out_data_q[12:0] == pphd_pkg::DUTY_T3 ||
                     out_data_q[12:0] == pphd_pkg::DUTY_T4 ||
                     out_data_q[12:0] == pphd_pkg::DUTY_T5))
    else $error("motor one duty is not a table value");

endmodule

/* design/pphd_tier.sv */
// ----------------------------------------------------------------------------
// pphd_tier: distance tier lane
// classifies one q8.8 reading into tier 0 (absent or far) through 5
// ----------------------------------------------------------------------------
module pphd_tier (
  input  pphd_pkg::dist_t dist_i,
  input  pphd_pkg::dist_t no_reading_level_i,
  output pphd_pkg::tier_t tier_o
);

  always_comb begin
    if (dist_i <= no_reading_level_i) begin
      tier_o = pphd_pkg::TIER_NONE;
    end else if (dist_i < pphd_pkg::Q_TWO) begin
      tier_o = 3'd1;
    end else if (dist_i < pphd_pkg::Q_THREE) begin
      tier_o = 3'd2;
    end else if (dist_i < pphd_pkg::Q_FOUR) begin
      tier_o = 3'd3;
    end else if (dist_i < pphd_pkg::Q_FIVE) begin
      tier_o = 3'd4;
    end else if (dist_i < pphd_pkg::Q_SIX) begin
      tier_o = 3'd5;
    end else begin
      tier_o = pphd_pkg::TIER_NONE;
    end
  end

endmodule

/* design/pphd_pair.sv */
// ----------------------------------------------------------------------------
// pphd_pair: neighbor pair lane
// decides which of the two motors a pair writes and with which duty
// ----------------------------------------------------------------------------
module pphd_pair (
  input  pphd_pkg::dist_t    dist_i_i,
  input  pphd_pkg::dist_t    dist_j_i,
  input  pphd_pkg::tier_t    tier_i_i,
  input  pphd_pkg::tier_t    tier_j_i,
  input  pphd_pkg::bound_t   near_span_i,
  output pphd_pkg::pair_wr_t wr_o
);

  logic signed [pphd_pkg::DIST_W:0] diff;
  logic [pphd_pkg::DIST_W:0]        abs_diff;
  logic                             act_i, act_j, share;
  pphd_pkg::duty_t                  own_i, own_j, shared;

  assign act_i = (tier_i_i != pphd_pkg::TIER_NONE);
  assign act_j = (tier_j_i != pphd_pkg::TIER_NONE);

  // 17-bit difference cannot overflow
  assign diff     = {dist_i_i[pphd_pkg::DIST_W-1], dist_i_i}
                  - {dist_j_i[pphd_pkg::DIST_W-1], dist_j_i};
  assign abs_diff = diff[pphd_pkg::DIST_W] ? 17'(-diff) : 17'(diff);

  assign share  = (tier_i_i == tier_j_i) ||
                  (abs_diff <= {2'b00, near_span_i});
  assign own_i  = pphd_pkg::duty_of_tier(tier_i_i);
  assign own_j  = pphd_pkg::duty_of_tier(tier_j_i);
  assign shared = (dist_i_i < dist_j_i) ? own_i : own_j;

  always_comb begin
    wr_o.wr_i   = act_i;
    wr_o.wr_j   = act_j;
    wr_o.duty_i = own_i;
    wr_o.duty_j = own_j;
    if (act_i && act_j && share) begin
      wr_o.duty_i = shared;
      wr_o.duty_j = shared;
    end
  end

endmodule
